/* src/bfmc_pkg.sv */
// Shared types and constants of the box filter mip chain.
`timescale 1ns / 1ps
package bfmc_pkg;

	localparam int CH_W   = 16;
	localparam int SUM_W  = 17;
	localparam int CFG_W  = 11;
	localparam int LG_W   = 4;
	localparam int LVL_W  = 4;
	localparam int POS_W  = 8;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 11'd512;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] alpha_in;
	} pixel_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [CH_W-1:0]  red_out;
		logic [CH_W-1:0]  green_out;
		logic [CH_W-1:0]  blue_out;
		logic [CH_W-1:0]  alpha_out;
		logic             last_of_run;
	} result_t;

	typedef logic [3:0][CH_W-1:0]  chan4_t;
	typedef logic [3:0][SUM_W-1:0] sum4_t;

endpackage

/* src/bfmc_ram.sv */
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module bfmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* src/bfmc_front.sv */
// Input acceptance, filtering of disabled images and the request queue.
`timescale 1ns / 1ps
module bfmc_front import bfmc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   enable,
	input  logic   restart,
	input  logic   in_valid,
	output logic   in_stall,
	input  pixel_t pixel,
	output logic   q_valid,
	output pixel_t q_data,
	input  logic   q_pop
);
	pixel_t     buf_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;

	assign in_stall = (count_q == 2'd2);
	assign push     = in_valid && !in_stall && enable;
	assign q_valid  = (count_q != 2'd0);
	assign q_data   = buf_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else if (restart) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (q_pop) begin
				rptr_q <= ~rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

/* src/bfmc_back.sv */
// Level engine: walks one request down the mip levels and emits averages.
`timescale 1ns / 1ps
module bfmc_back import bfmc_pkg::*; #(
	parameter int MAX_LOG2_SIZE = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [LG_W-1:0]  lg,
	input  logic             q_valid,
	input  pixel_t           q_data,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_stall,
	output result_t          result
);
	localparam int DW    = (MAX_LOG2_SIZE > 1) ? $clog2(MAX_LOG2_SIZE) : 1;
	localparam int CW    = MAX_LOG2_SIZE + 1;
	localparam int SLOTS = (1 << MAX_LOG2_SIZE) - 1;
	localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_AVG} state_t;

	state_t          state_q;
	logic [DW-1:0]   d_q;
	chan4_t          pix_q;
	chan4_t          pend_q [MAX_LOG2_SIZE];
	logic [CW-1:0]   col_q [MAX_LOG2_SIZE];
	logic [CW-1:0]   row_q [MAX_LOG2_SIZE];
	sum4_t           sums_s1;
	logic [CW-1:0]   col_s1;
	logic [CW-1:0]   row_s1;
	result_t         out_q;
	logic            out_valid_q;

	logic [CW-1:0]   col;
	logic [CW-1:0]   row;
	logic [CW:0]     size;
	logic            col_wrap;
	logic            row_wrap;
	sum4_t           sums;
	logic [CW:0]     base;
	logic [AW-1:0]   addr;
	logic            ram_we;
	logic            ram_re;
	sum4_t           ram_rdata;
	chan4_t          avg;
	logic [DW-1:0]   nidx;
	logic            at_bottom;
	logic            last;
	logic            out_free;
	logic [CW+7:0]   posx_w;
	logic [CW+7:0]   posy_w;
	logic [LG_W-1:0] shamt;

	always_comb begin
		col      = col_q[d_q];
		row      = row_q[d_q];
		shamt    = lg - LG_W'(d_q);
		size     = (CW+1)'(1) << shamt;
		col_wrap = ({1'b0, col} + (CW+1)'(1)) >= size;
		row_wrap = ({1'b0, row} + (CW+1)'(1)) >= size;
		for (int c = 0; c < 4; c++) begin
			sums[c] = SUM_W'(pend_q[d_q][c]) + SUM_W'(pix_q[c]);
			avg[c]  = CH_W'((18'(ram_rdata[c]) + 18'(sums_s1[c]) + 18'd2) >> 2);
		end
		base   = ((CW+1)'(1) << MAX_LOG2_SIZE) - ((CW+1)'(1) << (MAX_LOG2_SIZE - int'(d_q)));
		addr   = AW'(base + (CW+1)'(col >> 1));
		ram_we = (state_q == ST_STEP) && col[0] && !row[0];
		ram_re = (state_q == ST_STEP) && col[0] && row[0];
		nidx   = (d_q == DW'(MAX_LOG2_SIZE - 1)) ? d_q : d_q + DW'(1);
		at_bottom = ((LG_W+1)'(d_q) + (LG_W+1)'(1) == {1'b0, lg});
		last   = at_bottom || !(col_q[nidx][0] && row_q[nidx][0]);
		out_free = !out_valid_q || !out_stall;
		posx_w = {8'd0, col_s1} >> 1;
		posy_w = {8'd0, row_s1} >> 1;
		q_pop  = (state_q == ST_IDLE) && q_valid;
	end

	bfmc_ram #(.WIDTH(4 * SUM_W), .DEPTH(SLOTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr),
		.wdata (sums),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (ram_re) begin
			sums_s1 <= sums;
			col_s1  <= col;
			row_s1  <= row;
		end
		if (q_pop) begin
			pix_q <= chan4_t'(q_data);
		end else if (state_q == ST_AVG && out_free) begin
			pix_q <= avg;
		end
		if (state_q == ST_AVG && out_free) begin
			out_q.level       <= LVL_W'(d_q) + LVL_W'(1);
			out_q.pos_x       <= posx_w[7:0];
			out_q.pos_y       <= posy_w[7:0];
			out_q.red_out     <= avg[3];
			out_q.green_out   <= avg[2];
			out_q.blue_out    <= avg[1];
			out_q.alpha_out   <= avg[0];
			out_q.last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			d_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_LOG2_SIZE; i++) begin
				pend_q[i] <= '0;
				col_q[i]  <= '0;
				row_q[i]  <= '0;
			end
		end else if (restart) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < MAX_LOG2_SIZE; i++) begin
				pend_q[i] <= '0;
				col_q[i]  <= '0;
				row_q[i]  <= '0;
			end
		end else begin
			if (state_q == ST_AVG && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						d_q     <= '0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (col_wrap) begin
						col_q[d_q] <= '0;
						row_q[d_q] <= row_wrap ? '0 : row + CW'(1);
					end else begin
						col_q[d_q] <= col + CW'(1);
					end
					if (!col[0]) begin
						pend_q[d_q] <= pix_q;
						state_q     <= ST_IDLE;
					end else if (!row[0]) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					if (out_free) begin
						if (at_bottom) begin
							state_q <= ST_IDLE;
						end else begin
							d_q     <= d_q + DW'(1);
							state_q <= ST_STEP;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;
endmodule

/* src/box_filter_mipmap_chain_top.sv */
// A request is held in the two-entry input queue, dequeued in the idle state and walked down the
// levels: a step state for each visited level, and an averaging state for each result (row sum
// memory read) that registers it at the output; the queue accepts new requests until it is full.
// Reset clears registers to a 512 by 512 image; a register write restarts the image.
// Row sums live in a RAM without a clearing pass; every entry is written before it is read.
`timescale 1ns / 1ps
module box_filter_mipmap_chain_top import bfmc_pkg::*; #(
	parameter int MAX_LOG2_SIZE = 9
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  pixel_t            pixel,
	output logic              out_valid,
	input  logic              out_stall,
	output result_t           result
);
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic             wr;
	logic [LG_W-1:0]  lg_raw;
	logic [LG_W-1:0]  lg;
	logic             enabled;
	logic             q_valid;
	pixel_t           q_data;
	logic             q_pop;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(height_q) : DATA_W'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
		end else if (wr) begin
			if (paddr[2] == REG_WIDTH) begin
				width_q <= pwdata[CFG_W-1:0];
			end else begin
				height_q <= pwdata[CFG_W-1:0];
			end
		end
	end

	always_comb begin
		lg_raw = '0;
		for (int i = 0; i < CFG_W; i++) begin
			if (width_q[i]) begin
				lg_raw = LG_W'(i);
			end
		end
		enabled = (width_q == height_q) && (width_q != '0)
			&& ((width_q & (width_q - CFG_W'(1))) == '0)
			&& (int'(lg_raw) <= MAX_LOG2_SIZE);
		lg = enabled ? lg_raw : '0;
	end

	bfmc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (lg != '0),
		.restart  (wr),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.pixel    (pixel),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop)
	);

	bfmc_back #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.restart   (wr),
		.lg        (lg),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);
endmodule

/* src/bfmc_checker.sv */
// Port level checks of the mip chain, bound to the top level.
`timescale 1ns / 1ps
module bfmc_checker import bfmc_pkg::*; #(
	parameter int MAX_LOG2_SIZE = 9
) (
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready,
	input logic              in_valid,
	input logic              in_stall,
	input pixel_t            pixel,
	input logic              out_valid,
	input logic              out_stall,
	input result_t           result
);
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(pixel))
		else $error("Stalled request changed.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("Stalled result changed.");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result.level != '0 && int'(result.level) <= MAX_LOG2_SIZE)
		else $error("Result level out of range.");

	a_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(result.pos_x) < (1 << (MAX_LOG2_SIZE - int'(result.level)))
			&& int'(result.pos_y) < (1 << (MAX_LOG2_SIZE - int'(result.level))))
		else $error("Result position outside its level.");

	a_cfg_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready ##1 psel && (paddr[2] == $past(paddr[2]))
			|-> prdata[CFG_W-1:0] == $past(pwdata[CFG_W-1:0]))
		else $error("Register read does not return the written value.");
endmodule

bind box_filter_mipmap_chain_top bfmc_checker #(.MAX_LOG2_SIZE(MAX_LOG2_SIZE)) u_bfmc_checker (.*);
